[design/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants for the ray/triangle intersection unit
// Fixed-point widths, register codes and the records passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none
package rti_pkg;

  localparam int CoordW = 16;   // Q8.8 coordinate
  localparam int EdgeW  = 17;   // coordinate difference
  localparam int HW     = 34;   // h = dir x e2
  localparam int QW     = 35;   // q = s x e1
  localparam int PW     = 52;   // dot product term
  localparam int DotW   = 54;   // det, s.h, dir.q, e2.q
  localparam int QuotW  = 32;   // Q16.16 quotient bits
  localparam int FracT  = 16;   // fraction bits of t
  localparam int RemW   = DotW + 1;
  localparam int EpsW   = 32;
  localparam int TEpsW  = 16;
  localparam int DistW  = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EdgeW-1:0]  edge_t;
  typedef logic signed [DotW-1:0]   dot_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIR_X   = 3'd0,
    REG_DIR_Y   = 3'd1,
    REG_DIR_Z   = 3'd2,
    REG_DET_EPS = 3'd3,
    REG_T_EPS   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    dot_t det;
    dot_t sh;
    dot_t dq;
    dot_t num;
  } geom_t;

  typedef struct packed {
    logic reject;
    logic neg;
  } tag_t;

endpackage
`default_nettype wire

[design/rti_geom.sv]
// ----------------------------------------------------------------------------
// rti_geom: edge, cross product and dot product pipeline
// Five register stages: edges, cross terms, cross sums, dot terms, dot sums.
// ----------------------------------------------------------------------------
`default_nettype none
module rti_geom (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire rti_pkg::coord_t org [3],
  input  wire rti_pkg::coord_t va [3],
  input  wire rti_pkg::coord_t vb [3],
  input  wire rti_pkg::coord_t vc [3],
  input  wire rti_pkg::coord_t dir [3],
  output logic                out_vld,
  output rti_pkg::geom_t      geom
);
  import rti_pkg::*;

  logic [4:0] vld_r;

  edge_t e1_r [3], e2_r [3], s_r [3];
  edge_t e1b_r [3], e2b_r [3], sb_r [3];
  edge_t e1c_r [3], e2c_r [3], sc_r [3];
  logic signed [HW-2:0] ha_r [3], hb_r [3];
  logic signed [QW-2:0] qa_r [3], qb_r [3];
  logic signed [HW-1:0] h_r [3];
  logic signed [QW-1:0] q_r [3];
  logic signed [PW-1:0] pdet_r [3], psh_r [3], pdq_r [3], pnum_r [3];
  geom_t geom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1_r[i] <= EdgeW'(vb[i]) - EdgeW'(va[i]);
      e2_r[i] <= EdgeW'(vc[i]) - EdgeW'(va[i]);
      s_r[i]  <= EdgeW'(org[i]) - EdgeW'(va[i]);
      e1b_r[i] <= e1_r[i];
      e2b_r[i] <= e2_r[i];
      sb_r[i]  <= s_r[i];
      e1c_r[i] <= e1b_r[i];
      e2c_r[i] <= e2b_r[i];
      sc_r[i]  <= sb_r[i];
      h_r[i] <= HW'(ha_r[i]) - HW'(hb_r[i]);
      q_r[i] <= QW'(qa_r[i]) - QW'(qb_r[i]);
      pdet_r[i] <= PW'(e1c_r[i]) * PW'(h_r[i]);
      psh_r[i]  <= PW'(sc_r[i]) * PW'(h_r[i]);
      pdq_r[i]  <= PW'(dir[i]) * PW'(q_r[i]);
      pnum_r[i] <= PW'(e2c_r[i]) * PW'(q_r[i]);
    end
    ha_r[0] <= (HW-1)'(dir[1]) * (HW-1)'(e2_r[2]);
    hb_r[0] <= (HW-1)'(dir[2]) * (HW-1)'(e2_r[1]);
    ha_r[1] <= (HW-1)'(dir[2]) * (HW-1)'(e2_r[0]);
    hb_r[1] <= (HW-1)'(dir[0]) * (HW-1)'(e2_r[2]);
    ha_r[2] <= (HW-1)'(dir[0]) * (HW-1)'(e2_r[1]);
    hb_r[2] <= (HW-1)'(dir[1]) * (HW-1)'(e2_r[0]);
    qa_r[0] <= (QW-1)'(s_r[1]) * (QW-1)'(e1_r[2]);
    qb_r[0] <= (QW-1)'(s_r[2]) * (QW-1)'(e1_r[1]);
    qa_r[1] <= (QW-1)'(s_r[2]) * (QW-1)'(e1_r[0]);
    qb_r[1] <= (QW-1)'(s_r[0]) * (QW-1)'(e1_r[2]);
    qa_r[2] <= (QW-1)'(s_r[0]) * (QW-1)'(e1_r[1]);
    qb_r[2] <= (QW-1)'(s_r[1]) * (QW-1)'(e1_r[0]);
    geom_r.det <= DotW'(pdet_r[0]) + DotW'(pdet_r[1]) + DotW'(pdet_r[2]);
    geom_r.sh  <= DotW'(psh_r[0]) + DotW'(psh_r[1]) + DotW'(psh_r[2]);
    geom_r.dq  <= DotW'(pdq_r[0]) + DotW'(pdq_r[1]) + DotW'(pdq_r[2]);
    geom_r.num <= DotW'(pnum_r[0]) + DotW'(pnum_r[1]) + DotW'(pnum_r[2]);
  end

  assign out_vld = vld_r[4];
  assign geom    = geom_r;

endmodule
`default_nettype wire

[design/rti_div.sv]
// ----------------------------------------------------------------------------
// rti_div: pipelined restoring divider for t = num / det in Q16.16
// One setup stage with the overflow check, then one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rti_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire rti_pkg::tag_t               in_tag,
  input  wire logic [rti_pkg::DotW-1:0]    divisor,
  input  wire logic [rti_pkg::DotW-1:0]    dividend,
  output logic                             out_vld,
  output rti_pkg::tag_t                    out_tag,
  output logic                             out_sat,
  output logic [rti_pkg::QuotW-1:0]        quot
);
  import rti_pkg::*;

  logic                vld_r  [QuotW+1];
  tag_t                tag_r  [QuotW+1];
  logic                sat_r  [QuotW+1];
  logic [DotW-1:0]     dvs_r  [QuotW+1];
  logic [RemW-1:0]     rem_r  [QuotW+1];
  logic [QuotW-1:0]    lo_r   [QuotW+1];
  logic [QuotW-1:0]    q_r    [QuotW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    tag_r[0] <= in_tag;
    sat_r[0] <= {FracT'(0), dividend} >= {divisor, FracT'(0)};
    dvs_r[0] <= divisor;
    rem_r[0] <= RemW'(dividend[DotW-1:FracT]);
    lo_r[0]  <= {dividend[FracT-1:0], FracT'(0)};
    q_r[0]   <= '0;
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_bit
    logic [RemW-1:0] shifted;
    logic            ge;

    assign shifted = {rem_r[k][RemW-2:0], lo_r[k][QuotW-1]};
    assign ge      = shifted >= {1'b0, dvs_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      tag_r[k+1] <= tag_r[k];
      sat_r[k+1] <= sat_r[k];
      dvs_r[k+1] <= dvs_r[k];
      rem_r[k+1] <= ge ? shifted - {1'b0, dvs_r[k]} : shifted;
      lo_r[k+1]  <= {lo_r[k][QuotW-2:0], 1'b0};
      q_r[k+1]   <= {q_r[k][QuotW-2:0], ge};
    end
  end

  assign out_vld = vld_r[QuotW];
  assign out_tag = tag_r[QuotW];
  assign out_sat = sat_r[QuotW];
  assign quot    = q_r[QuotW];

endmodule
`default_nettype wire

[design/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect: Moller-Trumbore ray/triangle test in fixed point
// One item per cycle; busy stays low.
// Stages: 5 geometry, 1 classify, 1 divider setup, 32 quotient bits, 1 output.
// Synchronous active-low reset clears valids and loads register defaults.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_triangle_intersect (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rti_pkg::coord_t               in_origin_x,
  input  wire rti_pkg::coord_t               in_origin_y,
  input  wire rti_pkg::coord_t               in_origin_z,
  input  wire rti_pkg::coord_t               in_vertex_a_x,
  input  wire rti_pkg::coord_t               in_vertex_a_y,
  input  wire rti_pkg::coord_t               in_vertex_a_z,
  input  wire rti_pkg::coord_t               in_vertex_b_x,
  input  wire rti_pkg::coord_t               in_vertex_b_y,
  input  wire rti_pkg::coord_t               in_vertex_b_z,
  input  wire rti_pkg::coord_t               in_vertex_c_x,
  input  wire rti_pkg::coord_t               in_vertex_c_y,
  input  wire rti_pkg::coord_t               in_vertex_c_z,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic signed [rti_pkg::DistW-1:0]   out_distance,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rti_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rti_pkg::CfgDataW-1:0]  cfg_data
);
  import rti_pkg::*;

  coord_t            dir_r [3];
  logic [EpsW-1:0]   det_eps_r;
  logic [TEpsW-1:0]  t_eps_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r[0]  <= 16'sd256;
      dir_r[1]  <= 16'sd44;
      dir_r[2]  <= 16'sd25;
      det_eps_r <= 32'd17;
      t_eps_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIR_X:   dir_r[0]  <= coord_t'(cfg_data[CoordW-1:0]);
        REG_DIR_Y:   dir_r[1]  <= coord_t'(cfg_data[CoordW-1:0]);
        REG_DIR_Z:   dir_r[2]  <= coord_t'(cfg_data[CoordW-1:0]);
        REG_DET_EPS: det_eps_r <= cfg_data[EpsW-1:0];
        REG_T_EPS:   t_eps_r   <= cfg_data[TEpsW-1:0];
        default: ;
      endcase
    end
  end

  coord_t org [3], va [3], vb [3], vc [3];
  assign org = '{in_origin_x, in_origin_y, in_origin_z};
  assign va  = '{in_vertex_a_x, in_vertex_a_y, in_vertex_a_z};
  assign vb  = '{in_vertex_b_x, in_vertex_b_y, in_vertex_b_z};
  assign vc  = '{in_vertex_c_x, in_vertex_c_y, in_vertex_c_z};

  logic  geom_vld;
  geom_t geom;

  rti_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .org     (org),
    .va      (va),
    .vb      (vb),
    .vc      (vc),
    .dir     (dir_r),
    .out_vld (geom_vld),
    .geom    (geom)
  );

  // classify: normalize sign, parallel and barycentric rejection
  logic                   neg;
  logic signed [DotW:0]   adet, shn, dqn, numn;
  logic                   reject;
  logic                   cls_vld_r;
  tag_t                   cls_tag_r;
  logic [DotW-1:0]        adet_r, unum_r;

  always_comb begin
    neg  = geom.det < 0;
    adet = neg ? -(DotW+1)'(geom.det) : (DotW+1)'(geom.det);
    shn  = neg ? -(DotW+1)'(geom.sh)  : (DotW+1)'(geom.sh);
    dqn  = neg ? -(DotW+1)'(geom.dq)  : (DotW+1)'(geom.dq);
    numn = (DotW+1)'(geom.num);
    reject = (geom.det == '0) || (adet < (DotW+1)'(det_eps_r)) ||
             (shn < 0) || (shn > adet) || (dqn < 0) || (shn + dqn > adet);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_vld_r <= 1'b0;
    end else begin
      cls_vld_r <= geom_vld;
    end
    cls_tag_r.reject <= reject;
    cls_tag_r.neg    <= (numn < 0) ^ neg;
    adet_r <= adet[DotW-1:0];
    unum_r <= numn < 0 ? DotW'(-numn) : DotW'(numn);
  end

  logic              div_vld, div_sat;
  tag_t              div_tag;
  logic [QuotW-1:0]  quot;

  rti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cls_vld_r),
    .in_tag   (cls_tag_r),
    .divisor  (adet_r),
    .dividend (unum_r),
    .out_vld  (div_vld),
    .out_tag  (div_tag),
    .out_sat  (div_sat),
    .quot     (quot)
  );

  // saturate, sign and hit decision
  logic [QuotW:0]        mag, magc;
  logic signed [QuotW:0] t;
  logic                  out_valid_r, out_hit_r;
  logic [DistW-1:0]      out_dist_r;

  always_comb begin
    mag = div_sat ? {1'b1, QuotW'(0)} : {1'b0, quot};
    if (div_tag.neg) begin
      magc = (mag > {2'b01, (QuotW-1)'(0)}) ? {2'b01, (QuotW-1)'(0)} : mag;
      t    = -signed'(magc);
    end else begin
      magc = (mag > {2'b00, {(QuotW-1){1'b1}}}) ? {2'b00, {(QuotW-1){1'b1}}} : mag;
      t    = signed'(magc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
    out_hit_r  <= !div_tag.reject && (t > signed'({1'b0, QuotW'(t_eps_r)}));
    out_dist_r <= div_tag.reject ? '0 : t[DistW-1:0];
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = signed'(out_dist_r);

endmodule
`default_nettype wire
